// File: src/icmp_erf_pkg.sv
// ----------------------------------------------------------------------------
// ICMP echo reply filter package
// Shared types, codes and constants of the echo reply filter.
// ----------------------------------------------------------------------------
package icmp_erf_pkg;

  localparam int MAX_PACKET_BYTES_DEF = 2048;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_IDENT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_SEQUENCE = 2'd1;

  // Header and message constants
  localparam logic [7:0] PROTO_ICMP      = 8'd1;
  localparam logic [7:0] TYPE_ECHO_REPLY = 8'd0;
  localparam int         TTL_OFFSET      = 8;
  localparam int         PROTO_OFFSET    = 9;
  localparam int         ICMP_MIN_BYTES  = 8;

  // Header length in bytes (IHL times four) and offsets past it.
  localparam int HDR_W = 6;
  localparam int OFF_W = 7;

  typedef enum logic [1:0] {
    V_MATCH    = 2'd0,
    V_NOT_ICMP = 2'd1,
    V_SHORT    = 2'd2,
    V_MISMATCH = 2'd3
  } verdict_t;

  // One byte handed from the input register to the parser.
  typedef struct packed {
    logic       vld;
    logic       eop;
    logic [7:0] data;
  } step_t;

  // Verdict produced on the last byte of a packet.
  typedef struct packed {
    verdict_t   verdict;
    logic [7:0] hop_limit;
  } result_t;

endpackage

// File: src/icmp_erf_in_if.sv
// ----------------------------------------------------------------------------
// ICMP echo reply filter input channel
// Valid/ready channel carrying one packet byte and its last-byte mark.
// ----------------------------------------------------------------------------
interface icmp_erf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] pkt_byte;
  logic       end_of_packet;

  modport source (output valid, output pkt_byte, output end_of_packet, input ready);
  modport sink   (input valid, input pkt_byte, input end_of_packet, output ready);
endinterface

// File: src/icmp_erf_out_if.sv
// ----------------------------------------------------------------------------
// ICMP echo reply filter result channel
// Valid/ready channel carrying one verdict and the TTL of a matching reply.
// ----------------------------------------------------------------------------
interface icmp_erf_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] verdict;
  logic [7:0] hop_limit;

  modport source (output valid, output verdict, output hop_limit, input ready);
  modport sink   (input valid, input verdict, input hop_limit, output ready);
endinterface

// File: src/icmp_echo_reply_filter_unit.sv
// ----------------------------------------------------------------------------
// ICMP echo reply filter
// Checks received IPv4 packets, one byte per transfer, for a matching ICMP
// echo reply and reports one verdict per packet.
// ----------------------------------------------------------------------------
//  port       dir   payload                          transfer
//  in_ch      sink  pkt_byte[8], end_of_packet[1]    valid & ready
//  out_ch     src   verdict[2], hop_limit[8]         valid & ready
//  cfg_*      in    cfg_index[2], cfg_wdata[16]      cfg_wr_en
//
// One byte is taken every cycle while in_ch.ready is high. A byte is held in
// the input register and is parsed on the way out of it; the verdict of a
// packet is loaded into the result register at the edge where its last byte
// leaves the input register, and out_ch.valid is driven from that register.
// The input only stalls while a verdict waits on out_ch and the next last
// byte is already in the input register. Reset is synchronous on rst_n and
// clears all packet state and both compare registers.
// ----------------------------------------------------------------------------
module icmp_echo_reply_filter_unit #(
  parameter int MAX_PACKET_BYTES = icmp_erf_pkg::MAX_PACKET_BYTES_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  icmp_erf_in_if.sink                           in_ch,
  icmp_erf_out_if.source                        out_ch,
  input  logic                                  cfg_wr_en,
  input  logic [icmp_erf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [icmp_erf_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import icmp_erf_pkg::*;

  logic [15:0] exp_ident_r, exp_seq_r;

  logic        s1_vld_r;
  logic        s1_eop_r;
  logic [7:0]  s1_data_r;
  logic        adv;

  logic        out_vld_r;
  result_t     out_res_r;

  step_t       step;
  result_t     res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_ident_r <= '0;
      exp_seq_r   <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_EXPECTED_IDENT:    exp_ident_r <= cfg_wdata;
        CFG_EXPECTED_SEQUENCE: exp_seq_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // A last byte may only leave the input register when the result register
  // is free or being emptied in the same cycle.
  assign adv         = s1_vld_r && (!s1_eop_r || !out_vld_r || out_ch.ready);
  assign in_ch.ready = !s1_vld_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_eop_r  <= in_ch.end_of_packet;
      s1_data_r <= in_ch.pkt_byte;
    end
  end

  always_comb begin
    step.vld  = adv;
    step.eop  = s1_eop_r;
    step.data = s1_data_r;
  end

  icmp_erf_parse #(
    .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
  ) u_parse (
    .clk         (clk),
    .rst_n       (rst_n),
    .step_i      (step),
    .exp_ident_i (exp_ident_r),
    .exp_seq_i   (exp_seq_r),
    .res_o       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv && s1_eop_r) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_eop_r) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid     = out_vld_r;
  assign out_ch.verdict   = out_res_r.verdict;
  assign out_ch.hop_limit = out_res_r.hop_limit;

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_vld_r) |-> $past(adv && s1_eop_r))
    else $error("verdict appeared without a last byte");

  a_hop_only_on_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_res_r.verdict != V_MATCH |-> out_res_r.hop_limit == '0)
    else $error("hop limit given on a verdict other than match");

  a_stage_kept: assert property (@(posedge clk) disable iff (!rst_n)
    s1_vld_r && !adv |=> s1_vld_r && $stable(s1_data_r) && $stable(s1_eop_r))
    else $error("stalled byte in the input register was lost");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !out_ch.ready |-> !(adv && s1_eop_r))
    else $error("pending verdict overwritten");

endmodule

// File: src/icmp_erf_parse.sv
// ----------------------------------------------------------------------------
// ICMP echo reply filter parser
// Tracks the per-packet header fields and forms the verdict on the last byte.
// ----------------------------------------------------------------------------
module icmp_erf_parse #(
  parameter int MAX_PACKET_BYTES = icmp_erf_pkg::MAX_PACKET_BYTES_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  icmp_erf_pkg::step_t    step_i,
  input  logic [15:0]            exp_ident_i,
  input  logic [15:0]            exp_seq_i,
  output icmp_erf_pkg::result_t  res_o
);
  import icmp_erf_pkg::*;

  localparam int CNT_W = $clog2(MAX_PACKET_BYTES + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_PACKET_BYTES);

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [HDR_W-1:0] hdr_r, hdr_nxt;
  logic [7:0]       proto_r, proto_nxt;
  logic [7:0]       ttl_r, ttl_nxt;
  logic [7:0]       type_r, type_nxt;
  logic [15:0]      ident_r, ident_nxt;
  logic [15:0]      seq_r, seq_nxt;

  logic [HDR_W-1:0] hdr_cur;
  logic [CNT_W-1:0] off0, off4, off5, off6, off7, min_len;
  logic             take;

  always_comb begin
    hdr_cur = (cnt_r == '0) ? {step_i.data[3:0], 2'b00} : hdr_r;
    off0    = CNT_W'(hdr_cur);
    off4    = CNT_W'(OFF_W'(hdr_cur) + OFF_W'(4));
    off5    = CNT_W'(OFF_W'(hdr_cur) + OFF_W'(5));
    off6    = CNT_W'(OFF_W'(hdr_cur) + OFF_W'(6));
    off7    = CNT_W'(OFF_W'(hdr_cur) + OFF_W'(7));
    take    = (cnt_r < CNT_MAX);

    cnt_nxt   = cnt_r;
    hdr_nxt   = hdr_r;
    proto_nxt = proto_r;
    ttl_nxt   = ttl_r;
    type_nxt  = type_r;
    ident_nxt = ident_r;
    seq_nxt   = seq_r;

    // Bytes past the maximum packet size leave all fields untouched.
    if (take) begin
      cnt_nxt = cnt_r + CNT_W'(1);
      hdr_nxt = hdr_cur;
      if (cnt_r == CNT_W'(TTL_OFFSET))   ttl_nxt         = step_i.data;
      if (cnt_r == CNT_W'(PROTO_OFFSET)) proto_nxt       = step_i.data;
      if (cnt_r == off0)                 type_nxt        = step_i.data;
      if (cnt_r == off4)                 ident_nxt[15:8] = step_i.data;
      if (cnt_r == off5)                 ident_nxt[7:0]  = step_i.data;
      if (cnt_r == off6)                 seq_nxt[15:8]   = step_i.data;
      if (cnt_r == off7)                 seq_nxt[7:0]    = step_i.data;
    end

    min_len = CNT_W'(OFF_W'(hdr_nxt) + OFF_W'(ICMP_MIN_BYTES));

    res_o.hop_limit = '0;
    if (proto_nxt != PROTO_ICMP) begin
      res_o.verdict = V_NOT_ICMP;
    end else if (cnt_nxt < min_len) begin
      res_o.verdict = V_SHORT;
    end else if (type_nxt == TYPE_ECHO_REPLY && ident_nxt == exp_ident_i &&
                 seq_nxt == exp_seq_i) begin
      res_o.verdict   = V_MATCH;
      res_o.hop_limit = ttl_nxt;
    end else begin
      res_o.verdict = V_MISMATCH;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (step_i.vld && step_i.eop)) begin
      cnt_r   <= '0;
      hdr_r   <= '0;
      proto_r <= '0;
      ttl_r   <= '0;
      type_r  <= '0;
      ident_r <= '0;
      seq_r   <= '0;
    end else if (step_i.vld) begin
      cnt_r   <= cnt_nxt;
      hdr_r   <= hdr_nxt;
      proto_r <= proto_nxt;
      ttl_r   <= ttl_nxt;
      type_r  <= type_nxt;
      ident_r <= ident_nxt;
      seq_r   <= seq_nxt;
    end
  end

  a_cnt_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_MAX)
    else $error("byte count ran past the maximum packet size");

  a_clear_after_eop: assert property (@(posedge clk) disable iff (!rst_n)
    step_i.vld && step_i.eop |=> cnt_r == '0 && proto_r == '0)
    else $error("packet state not cleared after the last byte");

  a_hdr_held: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != '0 && !step_i.vld |=> $stable(hdr_r))
    else $error("header length changed without a byte");

endmodule

// File: test/testbench.sv
// ----------------------------------------------------------------------------
// ICMP echo reply filter testbench
// Streams IPv4 packets byte by byte into the filter under several idle and
// stall patterns and compares every verdict with a local parser model.
// ----------------------------------------------------------------------------
module testbench;
  import icmp_erf_pkg::*;

  localparam int MAX_PKT      = MAX_PACKET_BYTES_DEF;
  localparam int PHASE_ITEMS  = 280;
  localparam int HOLD_CYCLES  = 300;
  localparam int IDLE_LIMIT   = 4000;
  localparam int SETTLE       = 8;
  localparam int REPORT_LINES = 100;

  // Indexes past the two compare registers; writes to them are ignored.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  typedef struct {
    logic [7:0] data;
    logic       eop;
  } pkt_item_t;

  logic clk;
  logic rst_n;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  icmp_erf_in_if  in_if ();
  icmp_erf_out_if out_if ();

  icmp_echo_reply_filter_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_if),
    .out_ch    (out_if),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  pkt_item_t byte_q[$];
  result_t   verdict_q[$];
  int        queued;
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;
  bit        hold_req = 1'b0;
  bit        hold_done = 1'b0;
  int        hold_left = 0;
  bit        in_took = 1'b0;
  int        idle_cycles = 0;
  int        error_count = 0;

  // Filter model state
  logic [15:0] want_ident = '0;
  logic [15:0] want_seq = '0;
  logic [11:0] rx_count = '0;
  logic [5:0]  hdr_len = '0;
  logic [7:0]  rx_proto = '0;
  logic [7:0]  rx_ttl = '0;
  logic [7:0]  rx_type = '0;
  logic [15:0] rx_ident = '0;
  logic [15:0] rx_seq = '0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    error_count++;
    if (error_count <= REPORT_LINES)
      $display("testbench: mismatch %s got %0d expected %0d at %0t", what, got, want, $realtime);
  endtask

  // Parses one accepted byte and queues the verdict when it ends a packet.
  task automatic parse_packet_byte(input logic [7:0] b, input logic eop);
    result_t r;
    int      idx;
    int      hb;
    if (rx_count < MAX_PKT) begin
      idx = rx_count;
      if (idx == 0) hdr_len = {b[3:0], 2'b00};
      hb = hdr_len;
      if (idx == TTL_OFFSET) rx_ttl = b;
      if (idx == PROTO_OFFSET) rx_proto = b;
      if (idx == hb) rx_type = b;
      if (idx == hb + 4) rx_ident[15:8] = b;
      if (idx == hb + 5) rx_ident[7:0] = b;
      if (idx == hb + 6) rx_seq[15:8] = b;
      if (idx == hb + 7) rx_seq[7:0] = b;
      rx_count = rx_count + 12'd1;
    end
    if (eop) begin
      r.hop_limit = '0;
      if (rx_proto != PROTO_ICMP) begin
        r.verdict = V_NOT_ICMP;
      end else if (int'(rx_count) < int'(hdr_len) + ICMP_MIN_BYTES) begin
        r.verdict = V_SHORT;
      end else if (rx_type == TYPE_ECHO_REPLY && rx_ident == want_ident &&
                   rx_seq == want_seq) begin
        r.verdict   = V_MATCH;
        r.hop_limit = rx_ttl;
      end else begin
        r.verdict = V_MISMATCH;
      end
      verdict_q.push_back(r);
      rx_count = '0;
      hdr_len  = '0;
      rx_proto = '0;
      rx_ttl   = '0;
      rx_type  = '0;
      rx_ident = '0;
      rx_seq   = '0;
    end
  endtask

  // Samples both channels at the rising edge.
  always @(posedge clk) begin : monitor
    result_t exp_r;
    if (!rst_n) begin
      in_took     <= 1'b0;
      idle_cycles <= 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (verdict_q.size() == 0) begin
          report_mismatch("unexpected verdict", out_if.verdict, -1);
        end else begin
          exp_r = verdict_q.pop_front();
          if (out_if.verdict !== exp_r.verdict)
            report_mismatch("verdict", out_if.verdict, exp_r.verdict);
          if (out_if.hop_limit !== exp_r.hop_limit)
            report_mismatch("hop_limit", out_if.hop_limit, exp_r.hop_limit);
        end
      end
      in_took <= in_if.valid && in_if.ready;
      if (in_if.valid && in_if.ready)
        parse_packet_byte(in_if.pkt_byte, in_if.end_of_packet);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
    end
  end

  // Byte driver: offers the next pending byte once the current one is taken.
  always @(negedge clk) begin : byte_driver
    pkt_item_t item;
    if (rst_n && (!in_if.valid || in_took)) begin
      if (byte_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        item = byte_q.pop_front();
        in_if.valid         <= 1'b1;
        in_if.pkt_byte      <= item.data;
        in_if.end_of_packet <= item.eop;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Result receiver, with one long hold-off when the pressure phase asks.
  always @(negedge clk) begin
    if (hold_left != 0) begin
      out_if.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      out_if.ready <= 1'b0;
      hold_left    <= HOLD_CYCLES;
      hold_done    <= 1'b1;
    end else begin
      out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    while (idle_cycles < IDLE_LIMIT) @(posedge clk);
    $display("testbench: FAIL");
    $finish;
  end

  task automatic push_byte(input logic [7:0] b, input logic eop);
    pkt_item_t item;
    item.data = b;
    item.eop  = eop;
    byte_q.push_back(item);
    queued++;
  endtask

  function automatic logic [15:0] pick_field(input logic [15:0] want);
    int sel;
    sel = $urandom_range(99);
    if (sel < 70) return want;
    if (sel < 85) return 16'($urandom);
    return want ^ (16'd1 << $urandom_range(15));
  endfunction

  // Builds one packet; mostly echo replies aimed at the current compare
  // values, with a share of short, odd-header and non-ICMP packets.
  task automatic queue_random_packet(input int force_len, input bit tiny);
    logic [7:0]  pkt[$];
    logic [15:0] id;
    logic [15:0] sq;
    int          ihl;
    int          hb;
    int          len;
    int          sel;
    int          k;
    sel = $urandom_range(99);
    if (sel < 60) ihl = 5;
    else if (sel < 85) ihl = $urandom_range(0, 4);
    else ihl = $urandom_range(0, 15);
    hb  = ihl * 4;
    sel = $urandom_range(99);
    if (force_len > 0) len = force_len;
    else if (tiny || sel < 8) len = $urandom_range(1, 12);
    else if (sel < 18) len = $urandom_range(1, hb + 8);
    else len = hb + 8 + $urandom_range(0, 8);
    for (k = 0; k < len; k++) pkt.push_back(8'($urandom));
    pkt[0] = {($urandom_range(99) < 80) ? 4'h4 : 4'($urandom), 4'(ihl)};
    if (len > PROTO_OFFSET && $urandom_range(99) < 85) pkt[PROTO_OFFSET] = PROTO_ICMP;
    if (len > hb && $urandom_range(99) < 90) pkt[hb] = TYPE_ECHO_REPLY;
    id = pick_field(want_ident);
    sq = pick_field(want_seq);
    if (len > hb + 4) pkt[hb + 4] = id[15:8];
    if (len > hb + 5) pkt[hb + 5] = id[7:0];
    if (len > hb + 6) pkt[hb + 6] = sq[15:8];
    if (len > hb + 7) pkt[hb + 7] = sq[7:0];
    for (k = 0; k < len; k++) push_byte(pkt[k], k == len - 1);
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    case (idx)
      CFG_EXPECTED_IDENT:    want_ident = data;
      CFG_EXPECTED_SEQUENCE: want_seq = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Waits until every byte is taken and every verdict has come back.
  task automatic drain();
    while (byte_q.size() != 0 || in_if.valid || verdict_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  initial begin
    int k;
    rst_n               = 1'b0;
    cfg_wr_en           = 1'b0;
    cfg_index           = '0;
    cfg_wdata           = '0;
    in_if.valid         = 1'b0;
    in_if.pkt_byte      = '0;
    in_if.end_of_packet = 1'b0;
    out_if.ready        = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // A lone final byte: no protocol byte, so not ICMP.
    push_byte(8'hFF, 1'b1);
    // Zero header length: the ICMP fields overlap the IPv4 header.
    for (k = 0; k < 8; k++) push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(PROTO_ICMP, 1'b1);
    // Normal header but the message part is missing.
    push_byte(8'h45, 1'b0);
    for (k = 1; k < 9; k++) push_byte(8'($urandom), 1'b0);
    push_byte(PROTO_ICMP, 1'b1);
    drain();

    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 0;  recv_stall_pct = 0;
          write_cfg(CFG_EXPECTED_IDENT, 16'($urandom));
          write_cfg(CFG_EXPECTED_SEQUENCE, 16'($urandom));
          write_cfg(CFG_SPARE_A, 16'hFFFF);
          write_cfg(CFG_SPARE_B, 16'($urandom));
        end
        1: begin
          send_idle_pct = 80; recv_stall_pct = 0;
          write_cfg(CFG_EXPECTED_IDENT, 16'hFFFF);
          write_cfg(CFG_EXPECTED_SEQUENCE, 16'hFFFF);
        end
        2: begin
          send_idle_pct = 0;  recv_stall_pct = 80;
          write_cfg(CFG_EXPECTED_IDENT, 16'($urandom));
          write_cfg(CFG_EXPECTED_SEQUENCE, 16'h0000);
        end
        3: begin
          send_idle_pct = 10; recv_stall_pct = 10;
          write_cfg(CFG_EXPECTED_IDENT, 16'h0000);
          write_cfg(CFG_EXPECTED_SEQUENCE, 16'($urandom));
        end
        default: begin
          send_idle_pct = 0;  recv_stall_pct = 0;
          write_cfg(CFG_EXPECTED_IDENT, 16'($urandom));
          write_cfg(CFG_EXPECTED_SEQUENCE, 16'($urandom));
          hold_req = 1'b1;
        end
      endcase
      queued = 0;
      // Oversized packets: one exactly at the limit, one ending past it.
      if (phase == 0) begin
        queue_random_packet(MAX_PKT, 1'b0);
        queue_random_packet(MAX_PKT + 3, 1'b0);
        queued = 0;
      end
      while (queued < PHASE_ITEMS) queue_random_packet(0, phase == 4 && queued < 120);
      drain();
    end

    if (error_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

// File: filelist.f
src/icmp_erf_pkg.sv
src/icmp_erf_in_if.sv
src/icmp_erf_out_if.sv
src/icmp_erf_parse.sv
src/icmp_echo_reply_filter_unit.sv
test/testbench.sv
